// ----- design/twq_pkg.sv -----
package twq_pkg;

  typedef enum logic [1:0] {
    REQ_BLOCK       = 2'd0,
    REQ_UNBLOCK     = 2'd1,
    REQ_TICK        = 2'd2,
    REQ_RELEASE_ALL = 2'd3
  } req_t;

  localparam logic [1:0] ST_SIGNALED = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;

  typedef struct packed {
    logic push;
    logic reject;
    logic pop_emit;
    logic walk_begin;
    logic release_all;
    logic walk_step;
    logic flush;
  } twq_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic walk_done;
  } twq_sts_t;

endpackage

// ----- design/twq_ctrl.sv -----
module twq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         req_type,
  input  twq_pkg::twq_sts_t  sts,
  output twq_pkg::twq_cmd_t  cmd,
  output logic               busy
);
  import twq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_POP   = 4'b0010,
    S_WALK  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (req_t'(req_type)) inside
            REQ_BLOCK: begin
              if (sts.full) begin
                cmd.reject = 1'b1;
              end else begin
                cmd.push = 1'b1;
              end
            end
            REQ_UNBLOCK: begin
              if (!sts.empty) begin
                state_next = S_POP;
              end
            end
            REQ_TICK, REQ_RELEASE_ALL: begin
              if (!sts.empty) begin
                cmd.walk_begin  = 1'b1;
                cmd.release_all = (req_t'(req_type) == REQ_RELEASE_ALL);
                state_next      = S_WALK;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_POP: begin
        cmd.pop_emit = 1'b1;
        state_next   = S_IDLE;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_done) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  a_done_in_walk: assert property (@(posedge clk) disable iff (rst)
    sts.walk_done |-> state == S_WALK)
    else $error("walk completion outside of a walk");

  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("controller became busy without a request");

  a_walk_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_begin |-> !sts.empty)
    else $error("walk started on an empty queue");

endmodule

// ----- design/twq_datapath.sv -----
module twq_datapath #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int THREAD_ID_BITS = 8,
  parameter int TIME_BITS      = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  twq_pkg::twq_cmd_t         cmd,
  output twq_pkg::twq_sts_t         sts,
  input  logic [THREAD_ID_BITS-1:0] thread_id,
  input  logic [TIME_BITS-1:0]      timeout,
  output logic                      result_valid,
  output logic [THREAD_ID_BITS-1:0] thread_id_out,
  output logic [1:0]                status,
  output logic                      sem_increment,
  output logic                      last
);
  import twq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  logic [THREAD_ID_BITS-1:0] mem_thread [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]      mem_ticks  [QUEUE_DEPTH];

  logic [THREAD_ID_BITS-1:0] rd_thread;
  logic [TIME_BITS-1:0]      rd_ticks;

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_cnt;
  logic [CW-1:0] proc_cnt;
  logic [CW-1:0] wr_cnt;
  logic          valid_d;
  logic          release_mode;

  logic                      hold_valid;
  logic [THREAD_ID_BITS-1:0] hold_thread;
  logic [1:0]                hold_status;

  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic                      wr_en;
  logic [THREAD_ID_BITS-1:0] wr_thread;
  logic [TIME_BITS-1:0]      wr_ticks;
  logic [TIME_BITS-1:0]      ticks_dec;
  logic                      expired;
  logic                      remove;
  logic                      proc;
  logic                      walk_emit;

  assign proc      = cmd.walk_step & valid_d;
  assign ticks_dec = (rd_ticks == '0) ? '0 : rd_ticks - TIME_BITS'(1);
  assign expired   = (rd_ticks == TIME_BITS'(1));
  assign remove    = release_mode | expired;
  assign walk_emit = proc & remove & hold_valid;

  assign rd_addr   = cmd.walk_step ? wrap_add(head, rd_cnt[AW-1:0]) : head;
  assign wr_en     = cmd.push | (proc & !remove);
  assign wr_addr   = cmd.push ? wrap_add(head, count[AW-1:0])
                              : wrap_add(head, wr_cnt[AW-1:0]);
  assign wr_thread = cmd.push ? thread_id : rd_thread;
  assign wr_ticks  = cmd.push ? timeout : ticks_dec;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_thread[wr_addr] <= wr_thread;
      mem_ticks[wr_addr]  <= wr_ticks;
    end
    rd_thread <= mem_thread[rd_addr];
    rd_ticks  <= mem_ticks[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      rd_cnt     <= '0;
      proc_cnt   <= '0;
      wr_cnt     <= '0;
      valid_d    <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        count <= count + CW'(1);
      end else if (cmd.pop_emit) begin
        count <= count - CW'(1);
        head  <= wrap_add(head, AW'(1));
      end else if (cmd.flush) begin
        count <= wr_cnt;
      end

      if (cmd.walk_begin) begin
        rd_cnt     <= CW'(1);
        proc_cnt   <= '0;
        wr_cnt     <= '0;
        valid_d    <= 1'b1;
        hold_valid <= 1'b0;
      end else if (cmd.walk_step) begin
        if (rd_cnt < count) begin
          rd_cnt  <= rd_cnt + CW'(1);
          valid_d <= 1'b1;
        end else begin
          valid_d <= 1'b0;
        end
        if (proc) begin
          proc_cnt <= proc_cnt + CW'(1);
          if (remove) begin
            hold_valid <= 1'b1;
          end else begin
            wr_cnt <= wr_cnt + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_begin) begin
      release_mode <= cmd.release_all;
    end
    if (proc && remove) begin
      hold_thread <= rd_thread;
      hold_status <= release_mode ? ST_SIGNALED : ST_TIMEOUT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.reject | cmd.pop_emit | walk_emit | (cmd.flush & hold_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reject) begin
      thread_id_out <= thread_id;
      status        <= ST_REJECTED;
      sem_increment <= 1'b0;
      last          <= 1'b1;
    end else if (cmd.pop_emit) begin
      thread_id_out <= rd_thread;
      status        <= ST_SIGNALED;
      sem_increment <= 1'b0;
      last          <= 1'b1;
    end else if (walk_emit || cmd.flush) begin
      thread_id_out <= hold_thread;
      status        <= hold_status;
      sem_increment <= (hold_status == ST_TIMEOUT);
      last          <= cmd.flush;
    end
  end

  assign sts.empty     = (count == '0);
  assign sts.full      = (count == DEPTH_C);
  assign sts.walk_done = valid_d & ((proc_cnt + CW'(1)) == count);

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> count < DEPTH_C)
    else $error("push into a full queue");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_emit |=> count == $past(count) - CW'(1))
    else $error("pop did not reduce the entry count");

  a_walk_bounds: assert property (@(posedge clk) disable iff (rst)
    proc |-> (proc_cnt < count) && (wr_cnt <= proc_cnt))
    else $error("walk outside the stored entries");

endmodule

// ----- design/timed_wait_queue_unit.sv -----
// Wait queue of threads blocked on a semaphore, kept in memory as a ring.
// A request is transferred when start is high and busy is low. A block request
// leaves busy low, so it frees the unit at once; a rejected block gives its
// result in the next cycle. An unblock on a non-empty queue passes through the
// pop state before its result is registered. A tick or a release-all walks the
// stored entries through the shared read address, one entry per cycle, and keeps
// busy high until the walk and its flush are done. Results appear one per cycle
// on the result ports with result_valid high for exactly one cycle each; the
// receiver cannot stall them, so it must take every result in the cycle in which
// it is shown. The last result of a request carries last high.
module timed_wait_queue_unit #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int THREAD_ID_BITS = 8,
  parameter int TIME_BITS      = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                req_type,
  input  logic [THREAD_ID_BITS-1:0] thread_id,
  input  logic [TIME_BITS-1:0]      timeout,
  output logic                      result_valid,
  output logic [THREAD_ID_BITS-1:0] thread_id_out,
  output logic [1:0]                status,
  output logic                      sem_increment,
  output logic                      last
);
  import twq_pkg::*;

  twq_cmd_t cmd;
  twq_sts_t sts;

  twq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  twq_datapath #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS),
    .TIME_BITS      (TIME_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .thread_id     (thread_id),
    .timeout       (timeout),
    .result_valid  (result_valid),
    .thread_id_out (thread_id_out),
    .status        (status),
    .sem_increment (sem_increment),
    .last          (last)
  );

endmodule
